/* rtl/cfbc_pkg.sv */
// ----------------------------------------------------------------------------
// Coded frame block checker package
// Shared widths, constants, verdict codes and the per-frame summary type.
// ----------------------------------------------------------------------------
package cfbc_pkg;

   // Default frame size limit in bytes.
   localparam int MAX_FRAME_BYTES_DEF = 1048576;

   // Field widths of the stream payloads.
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 19;
   localparam int CLAIM_W   = 24;
   localparam int OFFSET_W  = 21;
   localparam int TOTAL_W   = 32;
   localparam int BUDGET_W  = 21;
   localparam int STEP_W    = 14;
   localparam int BUD99_W   = 28;
   localparam int RSP_W     = 192;

   // Frame layout.
   localparam int CLAIM_POS0  = 4;
   localparam int CLAIM_POS1  = 5;
   localparam int CLAIM_POS2  = 6;
   localparam int WALK_START  = 8;
   localparam int HDR_BYTES   = 8;
   localparam int DESC_LO_OFS = 2;
   localparam int DESC_HI_OFS = 3;
   localparam int EXT_STEP    = 8;
   localparam int EXT_BIT     = 15;

   // Ceiling test ratio: length * 100 >= budget * 99.
   localparam int CEIL_NUM = 100;
   localparam int CEIL_DEN = 99;

   // Saturation limits.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Frame verdict codes.
   typedef enum logic [1:0] {
      VERDICT_WHOLE   = 2'd0,
      VERDICT_SHORT   = 2'd1,
      VERDICT_SKIPPED = 2'd2
   } verdict_type;

   // Summary of one finished frame.
   typedef struct packed {
      verdict_type           verdict;
      logic                  overrun;
      logic [COUNT_W-1:0]    counted;
      logic [CLAIM_W-1:0]    claimed;
      logic [OFFSET_W-1:0]   walked;
      logic [OFFSET_W-1:0]   length;
      logic                  ceiling;
   } frame_sum_type;

endpackage

/* rtl/coded_frame_block_checker.sv */
// ----------------------------------------------------------------------------
// Coded frame block checker
// Checks that each encoded frame holds the blocks it claims and keeps
// saturating totals of whole, short and ceiling frames.
// ----------------------------------------------------------------------------
//  channel   dir  signals                     payload
//  req       in   req_tvalid/tready/tdata     frame_byte (tdata), last_byte (tlast)
//  rsp       out  rsp_tvalid/tready/tdata     one frame summary per frame
//  csr       in   csr_wr_en/csr_wr_data       ceiling_budget
//
//  One byte is taken every cycle unless a last byte is held back. A byte waits
//  in the input register; the summary is registered as the last byte leaves.
//  Reset is synchronous and clears the walk, the totals and ceiling_budget.
//  A result that is not yet taken holds back only a last byte; other bytes
//  keep flowing into the walker.
// ----------------------------------------------------------------------------
module coded_frame_block_checker #(
   parameter int MAX_FRAME_BYTES = cfbc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // frame_byte [7:0]
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // verdict [1:0], ran_past_end [2], blocks_counted [21:3],
   // blocks_claimed [45:22], bytes_walked [66:46], frame_length [87:67],
   // at_ceiling [88], whole_total [120:89], short_total [152:121],
   // ceiling_total [184:153], zero fill [191:185]
   output logic [cfbc_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic [cfbc_pkg::BUDGET_W-1:0]      csr_wr_data
);

   logic                             in_valid_ff;
   logic [cfbc_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                             in_last_ff;
   logic                             budget_nz_ff;
   logic [cfbc_pkg::BUD99_W-1:0]     budget_x99_ff;
   logic                             rsp_valid_ff;
   cfbc_pkg::frame_sum_type          rsp_sum_ff;
   cfbc_pkg::frame_sum_type          sum;
   logic [cfbc_pkg::TOTAL_W-1:0]     whole_ff, whole_in;
   logic [cfbc_pkg::TOTAL_W-1:0]     short_ff, short_in;
   logic [cfbc_pkg::TOTAL_W-1:0]     ceil_ff, ceil_in;
   logic                             out_free;
   logic                             advance;
   logic                             finish;

   // Handshake: the input register moves on unless a last byte meets a full
   // result register.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign finish     = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Budget register, kept with its scaled form for the ceiling test.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_nz_ff  <= 1'b0;
         budget_x99_ff <= '0;
      end else if (csr_wr_en) begin
         budget_nz_ff  <= (csr_wr_data != '0);
         budget_x99_ff <= cfbc_pkg::BUD99_W'(csr_wr_data) *
                          cfbc_pkg::BUD99_W'(cfbc_pkg::CEIL_DEN);
      end
   end

   cfbc_walker #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .frame_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .budget_nz  (budget_nz_ff),
      .budget_x99 (budget_x99_ff),
      .sum        (sum)
   );

   // Saturating totals, bumped as each frame finishes.
   always_comb begin
      whole_in = whole_ff;
      short_in = short_ff;
      ceil_in  = ceil_ff;
      if (finish) begin
         if (sum.verdict == cfbc_pkg::VERDICT_WHOLE && whole_ff != cfbc_pkg::TOTAL_MAX) begin
            whole_in = whole_ff + cfbc_pkg::TOTAL_W'(1);
         end
         if (sum.verdict == cfbc_pkg::VERDICT_SHORT && short_ff != cfbc_pkg::TOTAL_MAX) begin
            short_in = short_ff + cfbc_pkg::TOTAL_W'(1);
         end
         if (sum.ceiling && ceil_ff != cfbc_pkg::TOTAL_MAX) begin
            ceil_in = ceil_ff + cfbc_pkg::TOTAL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff <= '0;
         short_ff <= '0;
         ceil_ff  <= '0;
      end else begin
         whole_ff <= whole_in;
         short_ff <= short_in;
         ceil_ff  <= ceil_in;
      end
   end

   // Result register; totals change only at a finish, so they are read live.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         rsp_sum_ff <= sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, ceil_ff, short_ff, whole_ff,
                        rsp_sum_ff.ceiling, rsp_sum_ff.length, rsp_sum_ff.walked,
                        rsp_sum_ff.claimed, rsp_sum_ff.counted, rsp_sum_ff.overrun,
                        rsp_sum_ff.verdict};

   // A result appears only after a last byte leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |-> $past(finish))
      else $error("checker: result without a finished frame");

   // Input is held back only by a last byte facing a full result register.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("checker: input stalled without cause");

   // A ceiling frame is always a whole frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sum_ff.ceiling) |->
         (rsp_sum_ff.verdict == cfbc_pkg::VERDICT_WHOLE))
      else $error("checker: ceiling mark on a frame that is not whole");

   // A skipped frame carries no walk results.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sum_ff.verdict == cfbc_pkg::VERDICT_SKIPPED) |->
         (rsp_sum_ff.counted == '0 && rsp_sum_ff.walked == '0 && !rsp_sum_ff.overrun))
      else $error("checker: skipped frame with walk results");

   // Totals never move backward.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (whole_ff >= $past(whole_ff) && short_ff >= $past(short_ff) &&
                         ceil_ff >= $past(ceil_ff)))
      else $error("checker: a total decreased");

endmodule

/* rtl/cfbc_walker.sv */
// ----------------------------------------------------------------------------
// Coded frame block walker
// Follows the block headers of one frame byte by byte and, on the last byte,
// forms the frame summary from the state that byte leaves.
// ----------------------------------------------------------------------------
module cfbc_walker #(
   parameter int MAX_FRAME_BYTES = cfbc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [cfbc_pkg::BYTE_W-1:0]        frame_byte,
   input  logic                               last_byte,
   input  logic                               budget_nz,
   input  logic [cfbc_pkg::BUD99_W-1:0]       budget_x99,
   output cfbc_pkg::frame_sum_type            sum
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int HDR_W = POS_W + 1;
   localparam int MUL_W = POS_W + 7;
   localparam int CMP_W = (MUL_W > cfbc_pkg::BUD99_W) ? MUL_W : cfbc_pkg::BUD99_W;
   localparam int EXT_BIT_L = cfbc_pkg::EXT_BIT;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_ORDINARY = 2'd1,
      KIND_EXTENDED = 2'd2
   } kind_type;

   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic [cfbc_pkg::CLAIM_W-1:0]     claimed_ff, claimed_in;
   logic [POS_W-1:0]                 start_ff, start_in;
   logic [cfbc_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [HDR_W-1:0]                 hdr_ff, hdr_in;
   logic [cfbc_pkg::BYTE_W-1:0]      desc_lo_ff, desc_lo_in;
   kind_type                         kind_ff, kind_in;
   logic                             stopped_ff, stopped_in;
   logic [cfbc_pkg::COUNT_W-1:0]     counted_ff, counted_in;

   logic                             take;
   logic [HDR_W-1:0]                 pos_x;
   logic [15:0]                      desc;
   logic [cfbc_pkg::STEP_W-1:0]      new_step;
   logic [HDR_W-1:0]                 len_x;
   logic [HDR_W-1:0]                 walked;
   logic [cfbc_pkg::COUNT_W-1:0]     counted_f;
   logic                             overrun;
   logic                             whole;
   logic [CMP_W-1:0]                 len_x100;

   // Per-byte walk: claimed count bytes, descriptor bytes, header advance.
   always_comb begin
      pos_in     = pos_ff;
      claimed_in = claimed_ff;
      start_in   = start_ff;
      step_in    = step_ff;
      hdr_in     = hdr_ff;
      desc_lo_in = desc_lo_ff;
      kind_in    = kind_ff;
      stopped_in = stopped_ff;
      counted_in = counted_ff;
      take       = pos_ff < POS_W'(MAX_FRAME_BYTES);
      pos_x      = HDR_W'(pos_ff);
      desc       = {frame_byte, desc_lo_ff};
      new_step   = desc[EXT_BIT_L] ? cfbc_pkg::STEP_W'(cfbc_pkg::EXT_STEP)
                                   : {desc[11:0], 2'b00};
      if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == POS_W'(cfbc_pkg::CLAIM_POS0)) begin
            claimed_in[7:0] = frame_byte;
         end
         if (pos_ff == POS_W'(cfbc_pkg::CLAIM_POS1)) begin
            claimed_in[15:8] = frame_byte;
         end
         if (pos_ff == POS_W'(cfbc_pkg::CLAIM_POS2)) begin
            claimed_in[23:16] = frame_byte;
         end
         if (!stopped_ff) begin
            if (pos_x == hdr_ff + HDR_W'(cfbc_pkg::DESC_LO_OFS)) begin
               desc_lo_in = frame_byte;
            end else if (pos_x == hdr_ff + HDR_W'(cfbc_pkg::DESC_HI_OFS)) begin
               // The previous ordinary block is confirmed by this header.
               if (kind_ff == KIND_ORDINARY && counted_ff != cfbc_pkg::COUNT_MAX) begin
                  counted_in = counted_ff + cfbc_pkg::COUNT_W'(1);
               end
               start_in = hdr_ff[POS_W-1:0];
               step_in  = new_step;
               hdr_in   = hdr_ff + HDR_W'(new_step);
               if (desc[EXT_BIT_L]) begin
                  kind_in = KIND_EXTENDED;
               end else begin
                  kind_in    = KIND_ORDINARY;
                  stopped_in = (desc[11:0] == 12'd0);
               end
            end
         end
      end
   end

   // Frame summary from the state after the last byte.
   always_comb begin
      len_x     = HDR_W'(pos_in);
      walked    = '0;
      counted_f = counted_in;
      overrun   = 1'b0;
      if (kind_in == KIND_NONE) begin
         walked = HDR_W'(cfbc_pkg::WALK_START);
      end else if (HDR_W'(start_in) + HDR_W'(cfbc_pkg::HDR_BYTES) > len_x) begin
         walked = HDR_W'(start_in);
      end else if (stopped_in || (kind_in == KIND_ORDINARY && hdr_in > len_x)) begin
         overrun = 1'b1;
         walked  = HDR_W'(start_in);
      end else begin
         if (kind_in == KIND_ORDINARY && counted_in != cfbc_pkg::COUNT_MAX) begin
            counted_f = counted_in + cfbc_pkg::COUNT_W'(1);
         end
         walked = hdr_in;
      end
      whole    = !overrun && (cfbc_pkg::CLAIM_W'(counted_f) == claimed_in) &&
                 (walked == len_x);
      len_x100 = CMP_W'(pos_in) * CMP_W'(cfbc_pkg::CEIL_NUM);

      if (len_x < HDR_W'(cfbc_pkg::WALK_START)) begin
         sum.verdict = cfbc_pkg::VERDICT_SKIPPED;
         sum.overrun = 1'b0;
         sum.counted = '0;
         sum.claimed = '0;
         sum.walked  = '0;
         sum.ceiling = 1'b0;
      end else begin
         sum.verdict = whole ? cfbc_pkg::VERDICT_WHOLE : cfbc_pkg::VERDICT_SHORT;
         sum.overrun = overrun;
         sum.counted = counted_f;
         sum.claimed = claimed_in;
         sum.walked  = cfbc_pkg::OFFSET_W'(walked);
         sum.ceiling = whole && budget_nz && (len_x100 >= CMP_W'(budget_x99));
      end
      sum.length = cfbc_pkg::OFFSET_W'(pos_in);
   end

   // Walk state; a finished frame returns everything to the start values.
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff     <= '0;
         claimed_ff <= '0;
         start_ff   <= '0;
         step_ff    <= '0;
         hdr_ff     <= HDR_W'(cfbc_pkg::WALK_START);
         desc_lo_ff <= '0;
         kind_ff    <= KIND_NONE;
         stopped_ff <= 1'b0;
         counted_ff <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         claimed_ff <= claimed_in;
         start_ff   <= start_in;
         step_ff    <= step_in;
         hdr_ff     <= hdr_in;
         desc_lo_ff <= desc_lo_in;
         kind_ff    <= kind_in;
         stopped_ff <= stopped_in;
         counted_ff <= counted_in;
      end
   end

   // The next header offset always follows the last header read.
   assert property (@(posedge clock) disable iff (reset)
      (kind_ff != KIND_NONE) |-> (hdr_ff == HDR_W'(start_ff) + HDR_W'(step_ff)))
      else $error("walker: header offset out of step with block start");

   // The walk never starts below the first header offset.
   assert property (@(posedge clock) disable iff (reset)
      (kind_ff == KIND_NONE) |-> (hdr_ff == HDR_W'(cfbc_pkg::WALK_START)))
      else $error("walker: first header offset disturbed");

   // A stopped walk only follows an ordinary zero-length header.
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (kind_ff == KIND_ORDINARY && step_ff == '0))
      else $error("walker: stopped without a zero-length block");

endmodule

/* tb/sv/coded_frame_block_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coded frame block checker testbench
// Streams encoded frames into the checker one byte per transfer and checks
// every frame summary against an in-bench block walker. A short table of
// directed bytes comes first. Random frames follow: mostly well-formed with
// random content, plus noise, short frames, truncation, zero-length blocks
// and wrong claims. The run goes through several ceiling budgets and one
// long result stall.
// ----------------------------------------------------------------------------
module coded_frame_block_checker_tb;

   // Frame limit of the checker under test.
   localparam int FRAME_LIMIT = 16384;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BYTES = 260;

   // Result layout, most significant field first.
   typedef struct packed {
      logic [6:0]                    fill;
      logic [cfbc_pkg::TOTAL_W-1:0]  ceiling_total;
      logic [cfbc_pkg::TOTAL_W-1:0]  short_total;
      logic [cfbc_pkg::TOTAL_W-1:0]  whole_total;
      logic                          at_ceiling;
      logic [cfbc_pkg::OFFSET_W-1:0] frame_length;
      logic [cfbc_pkg::OFFSET_W-1:0] bytes_walked;
      logic [cfbc_pkg::CLAIM_W-1:0]  blocks_claimed;
      logic [cfbc_pkg::COUNT_W-1:0]  blocks_counted;
      logic                          ran_past_end;
      cfbc_pkg::verdict_type         verdict;
   } frame_report_type;

   // One row of the directed table; verdict and length count only if typed.
   typedef struct packed {
      logic [7:0]                    data;
      logic                          last;
      logic                          typed;
      cfbc_pkg::verdict_type         verdict;
      logic [cfbc_pkg::OFFSET_W-1:0] length;
   } stim_row_type;

   typedef enum logic [1:0] {
      HDR_NONE     = 2'd0,
      HDR_ORDINARY = 2'd1,
      HDR_EXTENDED = 2'd2
   } hdr_kind_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic [7:0]                      req_tdata;
   logic                            req_tlast;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [cfbc_pkg::RSP_W-1:0]      rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic                            csr_wr_en;
   logic [cfbc_pkg::BUDGET_W-1:0]   csr_wr_data;

   // Walker state of the frame in flight.
   logic [cfbc_pkg::OFFSET_W-1:0]   pos;
   logic [cfbc_pkg::CLAIM_W-1:0]    claim_acc;
   logic [cfbc_pkg::OFFSET_W-1:0]   blk_start;
   logic [14:0]                     blk_len;
   logic [7:0]                      desc_lo;
   hdr_kind_type                    hdr_kind;
   logic                            walk_stop;
   logic [cfbc_pkg::COUNT_W-1:0]    blocks_ok;
   logic [cfbc_pkg::TOTAL_W-1:0]    whole_tot;
   logic [cfbc_pkg::TOTAL_W-1:0]    short_tot;
   logic [cfbc_pkg::TOTAL_W-1:0]    ceil_tot;
   logic [cfbc_pkg::BUDGET_W-1:0]   budget_reg;

   frame_report_type      report_q [$];
   stim_row_type          typed_q [$];
   stim_row_type          dir_rows [25];
   logic [7:0]            frame_bytes [$];

   int mismatches    = 0;
   int results_seen  = 0;
   int burst_left    = 0;
   int budget_writes = 0;
   int frames_seen   = 0;
   int n_whole       = 0;
   int n_short       = 0;
   int n_skipped     = 0;
   int n_overrun     = 0;
   int n_ceiling     = 0;
   bit stall_done    = 1'b0;

   coded_frame_block_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Clear everything that belongs to one frame.
   function automatic void clear_walk();
      pos       = '0;
      claim_acc = '0;
      blk_start = '0;
      blk_len   = '0;
      desc_lo   = '0;
      hdr_kind  = HDR_NONE;
      walk_stop = 1'b0;
      blocks_ok = '0;
   endfunction

   // Advance the block walk by one accepted byte; on the last byte, queue the
   // frame summary that the checker has to produce.
   function automatic void walk_byte(logic [7:0] b, logic last);
      int unsigned      f;
      int unsigned      len;
      int unsigned      walked;
      int unsigned      counted;
      logic [15:0]      d;
      logic             over;
      logic             whole;
      logic             ceil;
      frame_report_type r;
      stim_row_type     t;
      if (32'(pos) < FRAME_LIMIT) begin
         if (pos >= 4 && pos <= 6) begin
            claim_acc[8*(pos-4) +: 8] = b;
         end
         if (!walk_stop) begin
            f = (hdr_kind == HDR_NONE) ? 32'(cfbc_pkg::WALK_START)
                                       : 32'(blk_start) + 32'(blk_len);
            if (32'(pos) == f + 32'(cfbc_pkg::DESC_LO_OFS)) begin
               desc_lo = b;
            end else if (32'(pos) == f + 32'(cfbc_pkg::DESC_HI_OFS)) begin
               d = {b, desc_lo};
               // The previous ordinary block is confirmed by this header.
               if (hdr_kind == HDR_ORDINARY && blocks_ok != cfbc_pkg::COUNT_MAX) begin
                  blocks_ok++;
               end
               blk_start = f[cfbc_pkg::OFFSET_W-1:0];
               if (d[cfbc_pkg::EXT_BIT]) begin
                  hdr_kind = HDR_EXTENDED;
                  blk_len  = 15'(cfbc_pkg::EXT_STEP);
               end else begin
                  hdr_kind  = HDR_ORDINARY;
                  blk_len   = {1'b0, d[11:0], 2'b00};
                  walk_stop = (d[11:0] == 12'h000);
               end
            end
         end
         pos++;
      end
      if (!last) begin
         return;
      end

      len     = 32'(pos);
      counted = 32'(blocks_ok);
      walked  = 0;
      over    = 1'b0;
      ceil    = 1'b0;
      r       = '0;
      frames_seen++;
      if (len < 32'(cfbc_pkg::HDR_BYTES)) begin
         r.verdict = cfbc_pkg::VERDICT_SKIPPED;
         claim_acc = '0;
         counted   = 0;
         n_skipped++;
      end else begin
         if (hdr_kind == HDR_NONE) begin
            walked = 32'(cfbc_pkg::WALK_START);
         end else if (32'(blk_start) + 32'(cfbc_pkg::HDR_BYTES) > len) begin
            walked = 32'(blk_start);
         end else if (walk_stop || (hdr_kind == HDR_ORDINARY &&
                                    32'(blk_start) + 32'(blk_len) > len)) begin
            over   = 1'b1;
            walked = 32'(blk_start);
         end else begin
            if (hdr_kind == HDR_ORDINARY && counted != 32'(cfbc_pkg::COUNT_MAX)) begin
               counted++;
            end
            walked = 32'(blk_start) + 32'(blk_len);
         end
         whole = !over && counted == 32'(claim_acc) && walked == len;
         if (whole) begin
            r.verdict = cfbc_pkg::VERDICT_WHOLE;
            if (whole_tot != cfbc_pkg::TOTAL_MAX) whole_tot++;
            n_whole++;
            if (budget_reg != 0 &&
                longint'(len) * cfbc_pkg::CEIL_NUM >=
                longint'(budget_reg) * cfbc_pkg::CEIL_DEN) begin
               ceil = 1'b1;
               if (ceil_tot != cfbc_pkg::TOTAL_MAX) ceil_tot++;
               n_ceiling++;
            end
         end else begin
            r.verdict = cfbc_pkg::VERDICT_SHORT;
            if (short_tot != cfbc_pkg::TOTAL_MAX) short_tot++;
            n_short++;
         end
      end
      if (over) n_overrun++;

      r.ran_past_end   = over;
      r.blocks_counted = counted[cfbc_pkg::COUNT_W-1:0];
      r.blocks_claimed = claim_acc;
      r.bytes_walked   = walked[cfbc_pkg::OFFSET_W-1:0];
      r.frame_length   = len[cfbc_pkg::OFFSET_W-1:0];
      r.at_ceiling     = ceil;
      r.whole_total    = whole_tot;
      r.short_total    = short_tot;
      r.ceiling_total  = ceil_tot;
      // Directed rows carry their verdict and length typed in.
      if (typed_q.size() != 0) begin
         t              = typed_q.pop_front();
         r.verdict      = t.verdict;
         r.frame_length = t.length;
      end
      report_q.push_back(r);
      clear_walk();
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare one result transfer with the oldest pending frame summary.
   function automatic void check_report(logic [cfbc_pkg::RSP_W-1:0] raw);
      frame_report_type got;
      frame_report_type want;
      got = raw;
      results_seen++;
      if (report_q.size() == 0) begin
         $display("%0t: result transfer with no frame pending, expected none, actual 0x%0h",
                  $time, raw);
         mismatches++;
         return;
      end
      want = report_q.pop_front();
      check_field("verdict",        want.verdict,        got.verdict);
      check_field("ran_past_end",   want.ran_past_end,   got.ran_past_end);
      check_field("blocks_counted", want.blocks_counted, got.blocks_counted);
      check_field("blocks_claimed", want.blocks_claimed, got.blocks_claimed);
      check_field("bytes_walked",   want.bytes_walked,   got.bytes_walked);
      check_field("frame_length",   want.frame_length,   got.frame_length);
      check_field("at_ceiling",     want.at_ceiling,     got.at_ceiling);
      check_field("whole_total",    want.whole_total,    got.whole_total);
      check_field("short_total",    want.short_total,    got.short_total);
      check_field("ceiling_total",  want.ceiling_total,  got.ceiling_total);
      check_field("zero fill",      want.fill,           got.fill);
   endfunction

   // Observe both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         whole_tot  = '0;
         short_tot  = '0;
         ceil_tot   = '0;
         budget_reg = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_report(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            walk_byte(req_tdata, req_tlast);
         end
      end
   end

   // Offer one byte; the sender runs in bursts with idle gaps in between.
   task automatic offer_byte(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++) begin
         offer_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   // Append one block: two random bytes, the descriptor, random filler.
   task automatic push_block(input logic [15:0] desc, input int n);
      int i;
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(desc[7:0]);
      frame_bytes.push_back(desc[15:8]);
      for (i = 4; i < n; i++) begin
         frame_bytes.push_back(8'($urandom));
      end
   endtask

   // Build one random frame: mostly well-formed, sometimes noise or damaged.
   task automatic make_frame();
      int          mode;
      int          nblk;
      int          nord;
      int          w;
      int          i;
      logic [23:0] claim;
      frame_bytes.delete();
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         repeat ($urandom_range(1, 7)) frame_bytes.push_back(8'($urandom));
         return;
      end
      if (mode < 14) begin
         repeat ($urandom_range(8, 48)) frame_bytes.push_back(8'($urandom));
         return;
      end
      nblk = $urandom_range(0, 5);
      nord = 0;
      repeat (cfbc_pkg::HDR_BYTES) frame_bytes.push_back(8'($urandom));
      for (i = 0; i < nblk; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            push_block(16'h8000 | 16'($urandom), cfbc_pkg::EXT_STEP);
         end else begin
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 60)
                                             : $urandom_range(1, 6);
            push_block({1'b0, 3'($urandom), 12'(w)}, 4 * w);
            nord++;
         end
      end
      case ($urandom_range(0, 9))
         0: claim = 24'(nord + 1);
         1: claim = (nord > 0) ? 24'(nord - 1) : 24'($urandom);
         2: claim = 24'($urandom);
         default: claim = 24'(nord);
      endcase
      frame_bytes[cfbc_pkg::CLAIM_POS0] = claim[7:0];
      frame_bytes[cfbc_pkg::CLAIM_POS1] = claim[15:8];
      frame_bytes[cfbc_pkg::CLAIM_POS2] = claim[23:16];
      // Damage the tail now and then.
      case ($urandom_range(0, 9))
         0: repeat ($urandom_range(1, 5)) void'(frame_bytes.pop_back());
         1: repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
         2: begin
            push_block({1'b0, 3'($urandom), 12'h000}, cfbc_pkg::HDR_BYTES);
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
   endtask

   task automatic run_random(input int goal);
      int sent;
      sent = 0;
      while (sent < goal) begin
         make_frame();
         send_frame();
         sent += frame_bytes.size();
      end
   endtask

   // Drain: wait for every summary, then let the pipeline go idle.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_budget(input logic [cfbc_pkg::BUDGET_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      budget_reg = v;
      budget_writes++;
   endtask

   // Result side: a random ready pattern, plus one long hold-off mid-run.
   initial begin : result_sink
      logic [15:0] pat;
      int          k;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         for (k = 0; k < 48; k++) begin
            @(negedge clock);
            if (!stall_done && results_seen >= 12) begin
               rsp_tready <= 1'b0;
               repeat (400) @(negedge clock);
               stall_done = 1'b1;
            end
            rsp_tready <= pat[k % 16];
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("coded_frame_block_checker verification failed");
      $finish;
   end

   initial begin : stimulus
      int i;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      // Single byte frame, an 8-byte frame with no blocks, and a frame with
      // one ordinary 8-byte block that it claims.
      dir_rows = '{
         '{8'hFF, 1'b1, 1'b1, cfbc_pkg::VERDICT_SKIPPED, 21'd1},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b1, 1'b1, cfbc_pkg::VERDICT_WHOLE, 21'd8},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h01, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h02, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'h00, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b0, 1'b0, cfbc_pkg::VERDICT_WHOLE, 21'd0},
         '{8'hFF, 1'b1, 1'b1, cfbc_pkg::VERDICT_WHOLE, 21'd16}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, with the reset budget of zero.
      for (i = 0; i < 25; i++) begin
         if (dir_rows[i].typed) typed_q.push_back(dir_rows[i]);
         offer_byte(dir_rows[i].data, dir_rows[i].last);
      end
      run_random(PHASE_BYTES);
      settle();

      // Budget one makes every whole frame a ceiling frame.
      write_budget(21'd1);
      run_random(PHASE_BYTES);
      settle();

      write_budget(21'd1048576);
      run_random(PHASE_BYTES);
      settle();

      write_budget(cfbc_pkg::BUDGET_W'($urandom_range(20, 60)));
      run_random(PHASE_BYTES);
      settle();

      write_budget(21'd0);
      run_random(PHASE_BYTES);
      settle();

      write_budget(cfbc_pkg::BUDGET_W'($urandom_range(8, 80)));
      run_random(PHASE_BYTES);
      settle();

      $display("Checked %0d frames: %0d whole, %0d short, %0d skipped, %0d overrun, %0d at ceiling.",
               frames_seen, n_whole, n_short, n_skipped, n_overrun, n_ceiling);
      $display("Used %0d budget writes and one long result stall.", budget_writes);
      if (mismatches == 0) begin
         $display("coded_frame_block_checker verification clean");
      end else begin
         $display("coded_frame_block_checker verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/cfbc_pkg.sv
rtl/cfbc_walker.sv
rtl/coded_frame_block_checker.sv
tb/sv/coded_frame_block_checker_tb.sv
